// ===== src/dacf_pkg.sv =====
// ============================================================================
// Detection alert cooldown filter package
// Shared types, sizes, register indexes and verdict codes for the filter.
// ============================================================================
package dacf_pkg;

    // Table geometry.
    localparam int NUM_CAMERAS = 16;
    localparam int NUM_CLASSES = 32;
    localparam int TABLE_DEPTH = NUM_CAMERAS * NUM_CLASSES;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Field widths.
    localparam int CAM_W   = 4;
    localparam int CLASS_W = 5;
    localparam int SCORE_W = 16;
    localparam int TIME_W  = 48;
    localparam int HOLD_W  = 32;
    localparam int MASK_W  = 32;
    localparam int CFG_W   = 32;
    localparam int INDEX_W = 2;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [TIME_W-1:0] time_t;

    // Configuration register indexes.
    typedef enum logic [INDEX_W-1:0] {
        REG_HOLD_OFF  = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_CLASS_EN  = 2'd2
    } reg_index_t;

    // Verdict codes.
    typedef enum logic [1:0] {
        VERDICT_FIRED     = 2'd0,
        VERDICT_LOW_SCORE = 2'd1,
        VERDICT_CLASS_OFF = 2'd2,
        VERDICT_COOLING   = 2'd3
    } verdict_t;

    // Input beat.
    typedef struct packed {
        logic [CAM_W-1:0]   cam_index;
        logic [CLASS_W-1:0] class_index;
        logic [SCORE_W-1:0] score;
        logic [TIME_W-1:0]  time_ms;
    } detect_t;

    // Result beat.
    typedef struct packed {
        logic               fire;
        verdict_t           verdict;
        logic [CAM_W-1:0]   cam_out;
        logic [CLASS_W-1:0] class_out;
    } result_t;

    // Wrap tables: every possible camera and class code mapped into the table.
    typedef addr_t [2**CAM_W-1:0]   cam_map_t;
    typedef addr_t [2**CLASS_W-1:0] class_map_t;

    function automatic cam_map_t build_cam_map();
        cam_map_t m;
        for (int i = 0; i < 2**CAM_W; i++)
        begin
            m[i] = ADDR_W'((i % NUM_CAMERAS) * NUM_CLASSES);
        end
        return m;
    endfunction

    function automatic class_map_t build_class_map();
        class_map_t m;
        for (int i = 0; i < 2**CLASS_W; i++)
        begin
            m[i] = ADDR_W'(i % NUM_CLASSES);
        end
        return m;
    endfunction

    localparam cam_map_t   CAM_BASE   = build_cam_map();
    localparam class_map_t CLASS_OFFS = build_class_map();

endpackage

// ===== src/dacf_table.sv =====
// ============================================================================
// Last fire time table
// One write port and one read port with registered read data.
// ============================================================================
module dacf_table
(
    input  logic            clk,
    input  logic            wen,
    input  dacf_pkg::addr_t waddr,
    input  dacf_pkg::time_t wdata,
    input  dacf_pkg::addr_t raddr,
    output dacf_pkg::time_t rdata
);
    import dacf_pkg::*;

    time_t mem [TABLE_DEPTH];
    time_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; a read at the address being written returns the old entry.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/detection_alert_cooldown_filter_top.sv =====
// ============================================================================
// Detection alert cooldown filter
// Per camera and class hold-off filter that decides whether a detection alerts.
// ============================================================================
// Usage:
//   A detection beat on item is taken at a rising edge where start is high and
//   busy is low. Every detection gives exactly one result beat on result,
//   marked by done for one cycle; the receiver cannot stall it.
//   Each detection passes the first-stage registers, then the result register.
//   Throughput: one detection per cycle unless busy, with no gaps. The rate
//   is set by the single read port and single write port of the time table;
//   a pair fired by the previous detection is forwarded around the table.
//   Configuration: cfg_wen, cfg_index and cfg_wdata write one register per
//   edge (hold-off, score threshold, class enable mask). Write only while no
//   detection is in flight.
//   Reset: rst_n is asynchronous and active low. It clears the configuration
//   and control registers; the block then sweeps the time table to zero, one
//   entry per cycle, over all TABLE_DEPTH entries (512 here) with busy high.
//   Configuration writes are taken during the sweep.
// ============================================================================
module detection_alert_cooldown_filter_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  dacf_pkg::detect_t                    item,
    input  logic                                 cfg_wen,
    input  logic [dacf_pkg::INDEX_W-1:0]         cfg_index,
    input  logic [dacf_pkg::CFG_W-1:0]           cfg_wdata,
    output logic                                 done,
    output dacf_pkg::result_t                    result
);
    import dacf_pkg::*;

    // Configuration registers.
    logic [HOLD_W-1:0]  hold_off_reg;
    logic [SCORE_W-1:0] threshold_reg;
    logic [MASK_W-1:0]  class_en_reg;

    // Clearing sweep.
    logic  clearing_reg;
    addr_t clr_addr_reg;

    // First stage registers.
    logic    s1_valid_reg;
    detect_t s1_item_reg;
    addr_t   s1_slot_reg;
    logic    s1_low_reg;
    logic    s1_off_reg;

    // Forwarding of the previous cycle's table write.
    logic  fwd_valid_reg;
    addr_t fwd_addr_reg;
    time_t fwd_data_reg;

    // Result register.
    logic    done_reg;
    result_t result_reg;

    logic            accept;
    addr_t           slot;
    time_t           rd_data;
    time_t           last_time;
    logic [TIME_W:0] diff;
    logic            too_soon;
    verdict_t        verdict;
    logic            fire_wr;
    logic            tbl_wen;
    addr_t           tbl_waddr;
    time_t           tbl_wdata;

    assign busy   = clearing_reg;
    assign accept = start && !clearing_reg;
    assign slot   = CAM_BASE[item.cam_index] + CLASS_OFFS[item.class_index];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_off_reg  <= '0;
            threshold_reg <= '0;
            class_en_reg  <= '0;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                REG_HOLD_OFF:  hold_off_reg  <= cfg_wdata[HOLD_W-1:0];
                REG_THRESHOLD: threshold_reg <= cfg_wdata[SCORE_W-1:0];
                REG_CLASS_EN:  class_en_reg  <= cfg_wdata[MASK_W-1:0];
                default:       ;
            endcase
        end
    end

    // Table clearing sweep after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // First stage: capture the detection and the early checks.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg <= item;
        s1_slot_reg <= slot;
        s1_low_reg  <= item.score < threshold_reg;
        s1_off_reg  <= (class_en_reg != '0) && !class_en_reg[item.class_index];
    end

    // Time table.
    dacf_table u_table
    (
        .clk   (clk),
        .wen   (tbl_wen),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (slot),
        .rdata (rd_data)
    );

    // Second stage: hold-off check against the stored time.
    always_comb
    begin
        last_time = (fwd_valid_reg && (fwd_addr_reg == s1_slot_reg)) ? fwd_data_reg
                                                                      : rd_data;
        diff      = {1'b0, s1_item_reg.time_ms} - {1'b0, last_time};
        too_soon  = (last_time != '0)
                 && (diff[TIME_W] || (diff[TIME_W-1:0] < TIME_W'(hold_off_reg)));
        if (s1_low_reg)
        begin
            verdict = VERDICT_LOW_SCORE;
        end
        else if (s1_off_reg)
        begin
            verdict = VERDICT_CLASS_OFF;
        end
        else if (too_soon)
        begin
            verdict = VERDICT_COOLING;
        end
        else
        begin
            verdict = VERDICT_FIRED;
        end
        fire_wr = s1_valid_reg && (verdict == VERDICT_FIRED);
    end

    // Table write: zero fill during the sweep, otherwise the fired time.
    always_comb
    begin
        if (clearing_reg)
        begin
            tbl_wen   = 1'b1;
            tbl_waddr = clr_addr_reg;
            tbl_wdata = '0;
        end
        else
        begin
            tbl_wen   = fire_wr;
            tbl_waddr = s1_slot_reg;
            tbl_wdata = s1_item_reg.time_ms;
        end
    end

    // Remember the last write for the detection read in the same cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= fire_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= s1_slot_reg;
        fwd_data_reg <= s1_item_reg.time_ms;
    end

    // Result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.fire      <= (verdict == VERDICT_FIRED);
        result_reg.verdict   <= verdict;
        result_reg.cam_out   <= s1_item_reg.cam_index;
        result_reg.class_out <= s1_item_reg.class_index;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
